// ----- rtl/u8dec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types, status codes and per-length tables shared by the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNEXPECTED = 2'd1,
        ST_TRUNCATED  = 2'd2,
        ST_OVERLONG   = 2'd3
    } status_t;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic [31:0] code_point;
        status_t     status;
        logic        last;
    } result_t;

    localparam int unsigned RESULT_W   = $bits(result_t);
    localparam logic [31:0] REPL_RESET = 32'h0000_FFFD;
    localparam logic [5:0]  PAYLOAD_M  = 6'h3F;

    // Value bits kept once a sequence of the given length is complete.
    function automatic logic [31:0] keep_mask(input logic [2:0] len);
        logic [31:0] m;
        begin
            case (len)
                3'd2:    m = 32'h0000_0FFF;
                3'd3:    m = 32'h0001_FFFF;
                3'd4:    m = 32'h003F_FFFF;
                3'd5:    m = 32'h07FF_FFFF;
                3'd6:    m = 32'hFFFF_FFFF;
                default: m = 32'h0000_0000;
            endcase
            return m;
        end
    endfunction

    // Smallest value that is not an overlong encoding for the given length.
    function automatic logic [31:0] min_value(input logic [2:0] len);
        logic [31:0] v;
        begin
            case (len)
                3'd2:    v = 32'h0000_0080;
                3'd3:    v = 32'h0000_0800;
                3'd4:    v = 32'h0001_0000;
                3'd5:    v = 32'h0020_0000;
                3'd6:    v = 32'h0400_0000;
                default: v = 32'h0000_0000;
            endcase
            return v;
        end
    endfunction

    // Sequence length announced by a lead byte (0xC0..0xFF).
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] l;
        begin
            if (b[7:2] == 6'b111111)
                l = 3'd6;
            else if (b[7:3] == 5'b11111)
                l = 3'd5;
            else if (b[7:4] == 4'b1111)
                l = 3'd4;
            else if (b[7:5] == 3'b111)
                l = 3'd3;
            else
                l = 3'd2;
            return l;
        end
    endfunction

endpackage

// ----- rtl/utf8_to_ucs4_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs4_decoder_unit
// Streaming UTF-8 to 32-bit code point decoder, sequences of 1 to 6 bytes.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata[7:0] in_byte, tuser flush
//  m_axis   | out       | tdata[31:0] code_point, tdata[33:32] status, tlast
//  cfg      | in        | cfg_data = replacement_code
//
//  A byte is decoded in the cycle its request is accepted; its results are
//  registered into a three-entry output queue whose head drives m_axis.
//  One byte per cycle is sustained while m_axis takes one result per cycle;
//  a truncated sequence then an ASCII byte makes two results for that byte.
//  s_axis_tready is high while at most one result is queued, so it does not
//  depend combinationally on m_axis_tready.
//  Reset clears the decoder state and queue and loads replacement code 0xFFFD.
//
module utf8_to_ucs4_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] flush
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] code_point, [33:32] status, rest 0
    output logic        m_axis_tlast,
    // Replacement code register write.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import u8dec_pkg::*;

    localparam int unsigned QDEPTH = 3;

    // Decoder state.
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;
    logic [31:0] repl_reg;

    // Output queue: entry 0 is the head.
    result_t     q_reg [QDEPTH];
    result_t     q_next [QDEPTH];
    logic [1:0]  count_reg, count_next;

    logic        in_acc;
    logic        out_pop;
    logic [7:0]  b;
    logic        is_cont;
    logic        is_ascii;
    logic [31:0] acc_shift;
    logic [31:0] value;
    logic        push0, push1;
    result_t     r0, r1;
    logic [1:0]  base;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (count_reg <= 2'd1);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    assign m_axis_tdata  = {6'b0, q_reg[0].status, q_reg[0].code_point};
    assign m_axis_tlast  = q_reg[0].last;

    assign b         = s_axis_tdata;
    assign is_cont   = (b[7:6] == 2'b10);
    assign is_ascii  = !b[7];
    // Six payload bits of a continuation byte are shifted into the accumulator.
    assign acc_shift = {acc_reg[25:0], b[5:0] & PAYLOAD_M};
    assign value     = acc_shift & keep_mask(len_reg);

    // Decode of one accepted byte: up to two results and the next state.
    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        len_next = len_reg;
        push0    = 1'b0;
        push1    = 1'b0;
        r0       = '{code_point: repl_reg, status: ST_TRUNCATED, last: 1'b1};
        r1       = '{code_point: {24'b0, b}, status: ST_OK, last: 1'b1};
        if (in_acc)
        begin
            if (s_axis_tuser)
            begin
                // Flush closes an open sequence; idle gives no result.
                push0    = (rem_reg != 3'd0);
                acc_next = '0;
                rem_next = '0;
                len_next = '0;
            end
            else if (rem_reg != 3'd0 && is_cont)
            begin
                if (rem_reg == 3'd1)
                begin
                    push0 = 1'b1;
                    if (value < min_value(len_reg))
                        r0.status = ST_OVERLONG;
                    else
                    begin
                        r0.code_point = value;
                        r0.status     = ST_OK;
                    end
                    acc_next = '0;
                    rem_next = '0;
                    len_next = '0;
                end
                else
                begin
                    acc_next = acc_shift;
                    rem_next = rem_reg - 3'd1;
                end
            end
            else
            begin
                // Either idle, or a non-continuation byte cutting a sequence
                // short: the truncation result comes first, then the byte
                // starts afresh.
                acc_next = '0;
                rem_next = '0;
                len_next = '0;
                if (rem_reg != 3'd0)
                begin
                    push0   = 1'b1;
                    r0.last = !is_ascii;
                    push1   = is_ascii;
                end
                else if (is_ascii)
                begin
                    push0 = 1'b1;
                    r0    = '{code_point: {24'b0, b}, status: ST_OK, last: 1'b1};
                end
                else if (is_cont)
                begin
                    push0 = 1'b1;
                    r0    = '{code_point: repl_reg, status: ST_UNEXPECTED, last: 1'b1};
                end
                if (!is_ascii && !is_cont)
                begin
                    acc_next = {24'b0, b};
                    len_next = lead_length(b);
                    rem_next = lead_length(b) - 3'd1;
                end
            end
        end
    end

    // Queue update: shift on pop, then write new results behind what stays.
    always_comb
    begin
        base = count_reg - {1'b0, out_pop};
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (out_pop && i < QDEPTH - 1)
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            if (push0 && base == 2'(i))
                q_next[i] = r0;
            if (push1 && base + 2'd1 == 2'(i))
                q_next[i] = r1;
        end
        count_next = base + {1'b0, push0} + {1'b0, push1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            rem_reg   <= '0;
            len_reg   <= '0;
            repl_reg  <= REPL_RESET;
            count_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                repl_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An open sequence always has a legal length and fewer bytes left than it.
    a_open_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != 3'd0) |-> (len_reg >= 3'd2 && len_reg <= 3'd6 && rem_reg < len_reg))
        else $error("open sequence with inconsistent length");

    // A flush always leaves the decoder idle.
    a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (rem_reg == 3'd0))
        else $error("sequence still open after flush");

    // An accepted ASCII byte always produces a result.
    a_ascii_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser && !s_axis_tdata[7])
        |=> m_axis_tvalid)
        else $error("ASCII byte produced no result");

    // A request that pushed a result always leaves the queue non-empty.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (count_reg != 2'd0 || !$past(push0)))
        else $error("accepted result lost from queue");

endmodule
